### design/xcrd_pkg.sv
// ----------------------------------------------------------------------------
// xcrd_pkg
// shared types and constants of the response deframer
// ----------------------------------------------------------------------------
package xcrd_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 255;

    localparam int unsigned POS_W   = 9;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned STAT_W  = 3;

    localparam logic [POS_W-1:0]  POS_LIMIT       = 9'd511;
    localparam logic [POS_W-1:0]  POS_MIN_FRAME   = 9'd5;
    localparam logic [POS_W-1:0]  POS_MAX_FRAME   = POS_W'(MAX_FRAME_BYTES);
    localparam logic [POS_W-1:0]  POS_FIRST_DATA  = 9'd4;
    localparam logic [POS_W-1:0]  POS_HOLD_START  = 9'd3;
    localparam logic [POS_W-1:0]  POS_START       = 9'd0;
    localparam logic [POS_W-1:0]  POS_SOURCE      = 9'd1;
    localparam logic [POS_W-1:0]  POS_LENGTH      = 9'd2;

    localparam logic [BYTE_W-1:0] START_CODE      = 8'h35;
    localparam logic [BYTE_W-1:0] ADDR_BROADCAST  = 8'h00;
    localparam logic [BYTE_W-1:0] ADDR_RELAY_A    = 8'h26;
    localparam logic [BYTE_W-1:0] ADDR_RELAY_B    = 8'h27;
    localparam logic [BYTE_W-1:0] ADDR_MOTORS     = 8'h30;

    localparam logic [STAT_W-1:0] ST_OK             = 3'd0;
    localparam logic [STAT_W-1:0] ST_INVALID_LENGTH = 3'd1;
    localparam logic [STAT_W-1:0] ST_MALFORMED      = 3'd2;
    localparam logic [STAT_W-1:0] ST_INVALID_SOURCE = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_CHECKSUM   = 3'd4;

    // output queue
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = 2;
    localparam int unsigned QCNT_W = 3;
    localparam logic [QCNT_W-1:0] QCNT_MAX  = QCNT_W'(QDEPTH);
    localparam logic [QCNT_W-1:0] QCNT_ROOM = QCNT_W'(QDEPTH - 2);

    localparam int unsigned OUT_TDATA_W = 16;

    typedef struct packed {
        logic                  is_status;
        logic [BYTE_W-1:0]     data_byte;
        logic [STAT_W-1:0]     status;
        logic                  last;
    } t_result;

    // up to two results per request, first one always in res0
    typedef struct packed {
        logic    push0;
        logic    push1;
        t_result res0;
        t_result res1;
    } t_push;

endpackage

### design/xcrd_frame_check.sv
// ----------------------------------------------------------------------------
// xcrd_frame_check
// per-byte frame state, mode decode and result generation
// ----------------------------------------------------------------------------
module xcrd_frame_check
    import xcrd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [BYTE_W-1:0] i_cfg_data,
    input  logic              i_accept,
    input  logic              i_has_byte,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic              i_end_of_read,
    output t_push             o_push
);

    logic [BYTE_W-1:0] r_expected_source;
    logic [POS_W-1:0]  r_byte_position, n_byte_position;
    logic [BYTE_W-1:0] r_running_xor, n_running_xor;
    logic [BYTE_W-1:0] r_held_byte, n_held_byte;
    logic              r_start_ok, n_start_ok;
    logic              r_source_ok, n_source_ok;
    logic [BYTE_W-1:0] r_length_field, n_length_field;

    logic              broadcast;
    logic              checked;
    logic              emit_data;
    logic [BYTE_W-1:0] data_val;
    logic [STAT_W-1:0] stat_val;
    logic [POS_W-1:0]  upd_pos;
    logic              upd_start, upd_source;
    logic [BYTE_W-1:0] upd_xor, upd_held, upd_len;
    t_result           data_res, stat_res;

    assign broadcast = (r_expected_source == ADDR_BROADCAST);
    assign checked   = (r_expected_source == ADDR_RELAY_A) ||
                       (r_expected_source == ADDR_RELAY_B) ||
                       (r_expected_source == ADDR_MOTORS);

    always_comb begin
        upd_pos    = r_byte_position;
        upd_start  = r_start_ok;
        upd_source = r_source_ok;
        upd_len    = r_length_field;
        upd_held   = r_held_byte;
        upd_xor    = r_running_xor;
        emit_data  = 1'b0;
        data_val   = i_rx_byte;
        if (i_has_byte) begin
            if (broadcast) begin
                emit_data = 1'b1;
            end else if (checked) begin
                if (r_byte_position == POS_START) begin
                    upd_start = (i_rx_byte == START_CODE);
                end else if (r_byte_position == POS_SOURCE) begin
                    upd_source = (i_rx_byte == r_expected_source);
                end else if (r_byte_position == POS_LENGTH) begin
                    upd_len = i_rx_byte;
                end
                // payload is delayed one byte so the checksum byte never goes out
                if (r_byte_position >= POS_FIRST_DATA && r_byte_position < POS_MAX_FRAME) begin
                    emit_data = 1'b1;
                    data_val  = r_held_byte;
                end
                if (r_byte_position >= POS_HOLD_START) begin
                    upd_held = i_rx_byte;
                end
                upd_xor = r_running_xor ^ i_rx_byte;
            end
            if (r_byte_position != POS_LIMIT) begin
                upd_pos = r_byte_position + POS_W'(1);
            end
        end
    end

    always_comb begin
        stat_val = ST_OK;
        if (broadcast) begin
            stat_val = (upd_pos == '0) ? ST_INVALID_LENGTH : ST_OK;
        end else if (checked) begin
            if (upd_pos < POS_MIN_FRAME || upd_pos > POS_MAX_FRAME) begin
                stat_val = ST_INVALID_LENGTH;
            end else if (!upd_start) begin
                stat_val = ST_MALFORMED;
            end else if (!upd_source) begin
                stat_val = ST_INVALID_SOURCE;
            end else if ({1'b0, upd_len} != upd_pos) begin
                stat_val = ST_INVALID_LENGTH;
            end else if (upd_xor != '0) begin
                stat_val = ST_BAD_CHECKSUM;
            end
        end
    end

    always_comb begin
        data_res           = '0;
        data_res.data_byte = data_val;
        stat_res           = '0;
        stat_res.is_status = 1'b1;
        stat_res.status    = stat_val;
        stat_res.last      = 1'b1;

        o_push = '0;
        if (i_accept) begin
            if (emit_data) begin
                o_push.push0 = 1'b1;
                o_push.res0  = data_res;
                o_push.push1 = i_end_of_read;
                o_push.res1  = stat_res;
            end else begin
                o_push.push0 = i_end_of_read;
                o_push.res0  = stat_res;
            end
        end
    end

    always_comb begin
        n_byte_position = r_byte_position;
        n_running_xor   = r_running_xor;
        n_held_byte     = r_held_byte;
        n_start_ok      = r_start_ok;
        n_source_ok     = r_source_ok;
        n_length_field  = r_length_field;
        if (i_accept) begin
            if (i_end_of_read) begin
                n_byte_position = '0;
                n_running_xor   = '0;
                n_held_byte     = '0;
                n_start_ok      = 1'b0;
                n_source_ok     = 1'b0;
                n_length_field  = '0;
            end else begin
                n_byte_position = upd_pos;
                n_running_xor   = upd_xor;
                n_held_byte     = upd_held;
                n_start_ok      = upd_start;
                n_source_ok     = upd_source;
                n_length_field  = upd_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_source <= '0;
            r_byte_position   <= '0;
            r_running_xor     <= '0;
            r_held_byte       <= '0;
            r_start_ok        <= 1'b0;
            r_source_ok       <= 1'b0;
            r_length_field    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_expected_source <= i_cfg_data;
            end
            r_byte_position <= n_byte_position;
            r_running_xor   <= n_running_xor;
            r_held_byte     <= n_held_byte;
            r_start_ok      <= n_start_ok;
            r_source_ok     <= n_source_ok;
            r_length_field  <= n_length_field;
        end
    end

    // a second result is only ever the closing status
    a_second_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.push1 |-> (o_push.push0 && o_push.res1.is_status && !o_push.res0.is_status))
        else $error("second result without a data result ahead of it");

    // frame state is clear after an end-of-read request
    a_clear_after_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_end_of_read) |=> (r_byte_position == '0 && r_running_xor == '0))
        else $error("frame state not cleared after end of read");

    // pass mode never produces data
    a_pass_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.push0 && !broadcast && !checked) |-> o_push.res0.is_status)
        else $error("data result in pass mode");

endmodule

### design/xcrd_out_queue.sv
// ----------------------------------------------------------------------------
// xcrd_out_queue
// small result queue, takes up to two results a cycle and gives one while its reader is ready
// ----------------------------------------------------------------------------
module xcrd_out_queue
    import xcrd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    t_result           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              pop;
    logic [QCNT_W-1:0] push_cnt;

    assign o_room   = (r_count <= QCNT_ROOM);
    assign o_valid  = (r_count != '0);
    assign o_result = r_mem[r_rd_ptr];
    assign pop      = o_valid && i_ready;
    assign push_cnt = QCNT_W'(i_push.push0) + QCNT_W'(i_push.push1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + push_cnt[QPTR_W-1:0];
        n_rd_ptr = pop ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count + push_cnt - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.push1) begin
            r_mem[r_wr_ptr + QPTR_W'(1)] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_MAX)
        else $error("result queue overflow");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push0 |-> o_room)
        else $error("results pushed without room");

    a_count_tracks_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count[QPTR_W-1:0] == (r_wr_ptr - r_rd_ptr)))
        else $error("queue count out of step with pointers");

endmodule

### design/xor_checked_response_deframer.sv
// ----------------------------------------------------------------------------
// xor_checked_response_deframer
// checks response frames byte by byte and emits payload bytes and a status
//
//   port group   dir  tdata                         tuser       tlast
//   s_axis       in   [7:0] rx_byte                 has_byte    end_of_read
//   m_axis       out  [7:0] data_byte [10:8] status is_status   last
//   cfg          in   [7:0] expected_source         -           -
//
// one request is taken every cycle while s_axis tready is high; its results
// land in a four-entry queue the following cycle
// an end-of-read request with a data byte can make two results, and the
// queue drains one per cycle while m_axis tready is high; s_axis tready
// drops only while fewer than two entries are free
// reset is synchronous active low and clears the frame state, the queue and
// the source register; cfg is always ready
// ----------------------------------------------------------------------------
module xor_checked_response_deframer
    import xcrd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [7:0]             i_s_axis_tdata,   // rx_byte
    input  logic                   i_s_axis_tuser,   // has_byte
    input  logic                   i_s_axis_tlast,   // end_of_read
    // result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // data_byte, status, zero fill
    output logic                   o_m_axis_tuser,   // is_status
    output logic                   o_m_axis_tlast,   // last
    // source address register
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [7:0]             i_cfg_data
);

    logic    accept;
    t_push   push;
    t_result result;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_s_axis_tvalid && o_s_axis_tready;

    xcrd_frame_check u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_has_byte    (i_s_axis_tuser),
        .i_rx_byte     (i_s_axis_tdata),
        .i_end_of_read (i_s_axis_tlast),
        .o_push        (push)
    );

    xcrd_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (o_s_axis_tready),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (result)
    );

    assign o_m_axis_tdata = {{(OUT_TDATA_W - BYTE_W - STAT_W){1'b0}},
                             result.status, result.data_byte};
    assign o_m_axis_tuser = result.is_status;
    assign o_m_axis_tlast = result.last;

endmodule

### tb/sv/xcrd_frame_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xcrd_frame_monitor
// watches the request, result and source-address channels of the response
// deframer, predicts the data bytes and the status of every frame and
// compares each result with the oldest prediction still waiting
// ----------------------------------------------------------------------------
module xcrd_frame_monitor
    import xcrd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [7:0]             i_s_tdata,    // rx_byte
    input  logic                   i_s_tuser,    // has_byte
    input  logic                   i_s_tlast,    // end_of_read
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,    // data_byte, status, zero fill
    input  logic                   i_m_tuser,    // is_status
    input  logic                   i_m_tlast,    // last
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [7:0]             i_cfg_data,
    output int                     o_errors,
    output int                     o_pending,
    output int                     o_results,
    output int                     o_statuses
);

    localparam int FILL_LSB = BYTE_W + STAT_W;

    logic [BYTE_W-1:0] src_addr;
    logic [POS_W-1:0]  frame_pos;
    logic [BYTE_W-1:0] frame_xor;
    logic [BYTE_W-1:0] held_payload;
    logic [BYTE_W-1:0] length_byte;
    logic              start_seen;
    logic              source_seen;

    t_result           deframed_due[$];
    t_result           oldest;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t ns: result %0d, %s mismatch: got %0h, expected %0h",
                 $time, o_results, what, got, want);
        o_errors++;
    endtask

    task automatic clear_frame();
        frame_pos    = '0;
        frame_xor    = '0;
        held_payload = '0;
        length_byte  = '0;
        start_seen   = 1'b0;
        source_seen  = 1'b0;
    endtask

    task automatic deframe_request(input logic has, input logic [7:0] b, input logic eor);
        logic [POS_W-1:0] p;
        logic             broadcast;
        logic             checked;
        t_result          r;
        broadcast = (src_addr == ADDR_BROADCAST);
        checked   = (src_addr == ADDR_RELAY_A) || (src_addr == ADDR_RELAY_B) ||
                    (src_addr == ADDR_MOTORS);
        if (has) begin
            p = frame_pos;
            if (broadcast) begin
                r = '0;
                r.data_byte = b;
                deframed_due.push_back(r);
            end else if (checked) begin
                case (p)
                    POS_START:  start_seen = (b == START_CODE);
                    POS_SOURCE: source_seen = (b == src_addr);
                    POS_LENGTH: length_byte = b;
                    default: ;
                endcase
                // payload goes out one byte late so the checksum byte never does
                if (p >= POS_FIRST_DATA && p < POS_MAX_FRAME) begin
                    r = '0;
                    r.data_byte = held_payload;
                    deframed_due.push_back(r);
                end
                if (p >= POS_HOLD_START)
                    held_payload = b;
                frame_xor = frame_xor ^ b;
            end
            if (p < POS_LIMIT)
                frame_pos = p + 1'b1;
        end
        if (eor) begin
            r = '0;
            r.is_status = 1'b1;
            r.last = 1'b1;
            r.status = ST_OK;
            if (broadcast) begin
                r.status = (frame_pos == '0) ? ST_INVALID_LENGTH : ST_OK;
            end else if (checked) begin
                if (frame_pos < POS_MIN_FRAME || frame_pos > POS_MAX_FRAME)
                    r.status = ST_INVALID_LENGTH;
                else if (!start_seen)
                    r.status = ST_MALFORMED;
                else if (!source_seen)
                    r.status = ST_INVALID_SOURCE;
                else if ({1'b0, length_byte} != frame_pos)
                    r.status = ST_INVALID_LENGTH;
                else if (frame_xor != '0)
                    r.status = ST_BAD_CHECKSUM;
            end
            deframed_due.push_back(r);
            clear_frame();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            src_addr = ADDR_BROADCAST;
            clear_frame();
            deframed_due.delete();
            o_errors   = 0;
            o_results  = 0;
            o_statuses = 0;
        end else begin
            // results are compared before this edge's request is predicted
            if (i_m_tvalid && i_m_tready) begin
                if (deframed_due.size() == 0) begin
                    report_mismatch("unexpected result", i_m_tdata, '0);
                end else begin
                    oldest = deframed_due.pop_front();
                    if (i_m_tuser !== oldest.is_status)
                        report_mismatch("is_status", i_m_tuser, oldest.is_status);
                    if (i_m_tdata[BYTE_W-1:0] !== oldest.data_byte)
                        report_mismatch("data_byte", i_m_tdata[BYTE_W-1:0], oldest.data_byte);
                    if (i_m_tdata[FILL_LSB-1:BYTE_W] !== oldest.status)
                        report_mismatch("status", i_m_tdata[FILL_LSB-1:BYTE_W], oldest.status);
                    if (i_m_tdata[OUT_TDATA_W-1:FILL_LSB] !== '0)
                        report_mismatch("tdata fill", i_m_tdata[OUT_TDATA_W-1:FILL_LSB], '0);
                    if (i_m_tlast !== oldest.last)
                        report_mismatch("last", i_m_tlast, oldest.last);
                    if (oldest.is_status)
                        o_statuses++;
                end
                o_results++;
            end
            // a source written at this edge applies from the next request on
            if (i_s_tvalid && i_s_tready)
                deframe_request(i_s_tuser, i_s_tdata, i_s_tlast);
            if (i_cfg_valid && i_cfg_ready)
                src_addr = i_cfg_data;
        end
        o_pending = deframed_due.size();
    end

endmodule

### tb/sv/xor_checked_response_deframer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xor_checked_response_deframer_tb
// drives response reads into the deframer under every source-address mode:
// directed frames first, then random phases of well-formed, damaged and noise
// frames with random gaps and stalls on both streams, plus the longest legal
// frame, an overlong one and one that runs the byte counter to its ceiling
// ----------------------------------------------------------------------------
module xor_checked_response_deframer_tb;
    import xcrd_pkg::*;

    localparam int ITEMS_TARGET = 1150;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 4;
    localparam int SHORT_FRAME  = 16;

    typedef enum int {
        FLAW_NONE,
        FLAW_START,
        FLAW_SOURCE,
        FLAW_LENGTH,
        FLAW_CHECKSUM
    } t_flaw;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;    // rx_byte
    logic                   s_tuser;    // has_byte
    logic                   s_tlast;    // end_of_read
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;    // data_byte, status, zero fill
    logic                   m_tuser;    // is_status
    logic                   m_tlast;    // last
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [7:0]             cfg_data;

    int errors;
    int pending;
    int results;
    int statuses;

    int   items_sent = 0;
    int   frames_sent = 0;
    int   settings_written = 0;
    int   cycle_count = 0;
    bit   tx_burst = 1'b0;
    bit   rx_burst = 1'b0;
    logic [7:0] frame_bytes[$];

    xor_checked_response_deframer dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    xcrd_frame_monitor frame_monitor (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_s_tlast   (s_tlast),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results),
        .o_statuses  (statuses)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("xor_checked_response_deframer_tb: done, errors");
        $finish;
    end

    // result side: random stall before each result, none while rx_burst is set
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
        end
    end

    // leaves tvalid high after the request so a back-to-back one needs no dip
    task automatic send_request(input logic has, input logic [7:0] b, input logic eor);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = has;
        s_tdata  = b;
        s_tlast  = eor;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_source(input logic [7:0] addr);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_data  = addr;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        settings_written++;
    endtask

    task automatic build_checked(input int n, input logic [7:0] src, input t_flaw flaw);
        logic [7:0] xsum;
        frame_bytes.delete();
        for (int i = 0; i < n; i++) begin
            if (i == 0)
                frame_bytes.push_back(START_CODE);
            else if (i == 1)
                frame_bytes.push_back(src);
            else if (i == 2)
                frame_bytes.push_back(8'(n));
            else
                frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if (flaw == FLAW_START && n > 0)
            frame_bytes[0] ^= 8'($urandom_range(1, 255));
        if (flaw == FLAW_SOURCE && n > 1)
            frame_bytes[1] ^= 8'($urandom_range(1, 255));
        if (flaw == FLAW_LENGTH && n > 2)
            frame_bytes[2] ^= 8'($urandom_range(1, 255));
        if (n >= 4) begin
            xsum = '0;
            for (int i = 0; i < n - 1; i++)
                xsum ^= frame_bytes[i];
            frame_bytes[n-1] = xsum;
        end
        if (flaw == FLAW_CHECKSUM && n > 0)
            frame_bytes[n-1] ^= 8'($urandom_range(1, 255));
    endtask

    task automatic build_noise(input int n);
        frame_bytes.delete();
        repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // end_of_read rides on the last byte, or on an empty request after it
    // idle requests are mixed into short frames only
    task automatic send_frame(input bit split_eor);
        int last_idx;
        last_idx = frame_bytes.size() - 1;
        for (int i = 0; i <= last_idx; i++) begin
            if (last_idx < SHORT_FRAME && $urandom_range(0, 7) == 0)
                send_request(1'b0, 8'($urandom_range(0, 255)), 1'b0);
            send_request(1'b1, frame_bytes[i], !split_eor && i == last_idx);
        end
        if (split_eor || last_idx < 0)
            send_request(1'b0, 8'($urandom_range(0, 255)), 1'b1);
        frames_sent++;
    endtask

    task automatic send_random_frame(input logic [7:0] addr, input bit checked);
        int pick;
        pick = $urandom_range(0, 15);
        if (!checked)
            build_noise($urandom_range(0, 10));
        else if (pick < 10)
            build_checked($urandom_range(5, 12), addr, FLAW_NONE);
        else if (pick < 14)
            build_checked($urandom_range(5, 12), addr, t_flaw'($urandom_range(1, 4)));
        else if (pick == 14)
            build_checked($urandom_range(0, 4), addr, FLAW_NONE);
        else
            build_noise($urandom_range(0, 10));
        send_frame($urandom_range(0, 3) == 0);
    endtask

    function automatic logic [7:0] pick_source();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 3:    return ADDR_RELAY_A;
            1, 4:    return ADDR_RELAY_B;
            2, 5:    return ADDR_MOTORS;
            6, 7:    return ADDR_BROADCAST;
            8:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        logic [7:0] addr;
        bit         checked;
        int         phase;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // broadcast out of reset: empty read, idle request, extreme bytes
        send_request(1'b0, 8'hA5, 1'b1);
        send_request(1'b0, 8'h5A, 1'b0);
        send_request(1'b1, 8'h00, 1'b0);
        send_request(1'b1, 8'hFF, 1'b1);

        write_source(ADDR_RELAY_A);
        build_checked(5, ADDR_RELAY_A, FLAW_NONE);
        send_frame(1'b0);

        // pass mode counts a byte, then the frame goes on in checked mode
        write_source(8'hFF);
        send_request(1'b1, 8'hAA, 1'b0);
        write_source(ADDR_RELAY_B);
        frame_bytes = {8'h27, 8'h05, 8'hC3, 8'hE1};
        send_frame(1'b0);

        write_source(ADDR_MOTORS);
        build_checked(5, ADDR_MOTORS, FLAW_NONE);
        send_frame(1'b1);
        send_request(1'b0, 8'h00, 1'b1);

        phase = 0;
        while (items_sent < ITEMS_TARGET) begin
            case (phase)
                1: begin
                    write_source(ADDR_RELAY_B);
                    build_checked(MAX_FRAME_BYTES, ADDR_RELAY_B, FLAW_NONE);
                    send_frame($urandom_range(0, 1));
                end
                3: begin
                    write_source(ADDR_MOTORS);
                    build_checked(MAX_FRAME_BYTES + 1, ADDR_MOTORS, FLAW_NONE);
                    send_frame(1'b1);
                end
                5: begin
                    // one byte past the counter ceiling, closed by an empty read
                    write_source(ADDR_BROADCAST);
                    build_noise(int'(POS_LIMIT) + 1);
                    send_frame(1'b1);
                end
                default: begin
                    addr = pick_source();
                    checked = (addr == ADDR_RELAY_A) || (addr == ADDR_RELAY_B) ||
                              (addr == ADDR_MOTORS);
                    write_source(addr);
                    tx_burst = ($urandom_range(0, 3) == 0);
                    rx_burst = ($urandom_range(0, 3) == 0);
                    repeat ($urandom_range(2, 6)) begin
                        send_random_frame(addr, checked);
                        if ($urandom_range(0, 5) == 0)
                            wait_drained();
                    end
                end
            endcase
            phase++;
        end

        s_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (16) @(negedge clk);

        $display("sent %0d requests in %0d frames over %0d source settings",
                 items_sent, frames_sent, settings_written);
        $display("compared %0d results, %0d of them frame status, %0d mismatches",
                 results, statuses, errors);
        if (errors == 0)
            $display("xor_checked_response_deframer_tb: done, clean");
        else
            $display("xor_checked_response_deframer_tb: done, errors");
        $finish;
    end

endmodule
